[hdl/assert_macros.svh]
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pbrle_pkg.sv]
// shared types, constants and command/status structs of the run-length encoder
`default_nettype none

package pbrle_pkg;

    // default encoding limits
    localparam int MIN_RUN_DEF = 3;
    localparam int MAX_RUN_DEF = 130;
    localparam int MIN_LIT_DEF = 1;
    localparam int MAX_LIT_DEF = 32;

    // fixed field widths
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 8;
    localparam int TOTAL_W = 32;

    // offset added to a literal block header
    localparam logic [BYTE_W-1:0] LIT_BIAS = 8'd128;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MOVE,
        ST_LF_HDR,
        ST_LF_DATA,
        ST_RUN_HDR,
        ST_RUN_VAL,
        ST_FINISH
    } state_t;

    // where a literal flush continues when it is done
    typedef enum logic [1:0] {
        PH_RUN,
        PH_MOVE,
        PH_FINAL
    } phase_t;

    // what the current transaction does once the open run is closed
    typedef enum logic [1:0] {
        K_NEW,
        K_MAX,
        K_END
    } kind_t;

    // source of an emitted byte
    typedef enum logic [1:0] {
        SRC_LIT_HDR,
        SRC_LIT_DATA,
        SRC_RUN_HDR,
        SRC_RUN_VAL
    } emit_src_t;

    // commands from controller to datapath
    typedef struct packed {
        logic      capture;
        logic      inc_len;
        logic      add_lit;
        logic      emit;
        emit_src_t src;
        logic      lit_advance;
        logic      clear_run;
        logic      load_run;
        logic      push_final;
        logic      reset_all;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic op_end;
        logic match;
        logic len_next_max;
        logic len_ge_min;
        logic len_zero;
        logic lit_zero;
        logic lit_fill_next;
        logic flush_last;
        logic emit_ready;
        logic out_free;
        logic stage_valid;
    } dp_status_t;

endpackage

`default_nettype wire

[hdl/pbrle_ram.sv]
// generic single-write, single-read memory with registered read data
`default_nettype none

module pbrle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[hdl/pbrle_ctrl.sv]
// controller state machine that sequences runs, literal moves and flushes
`default_nettype none

module pbrle_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire pbrle_pkg::dp_status_t status,
    output pbrle_pkg::dp_cmd_t         cmd
);

    pbrle_pkg::state_t state_reg, state_next;
    pbrle_pkg::phase_t phase_reg, phase_next;
    pbrle_pkg::kind_t  kind_reg,  kind_next;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pbrle_pkg::ST_IDLE;
            phase_reg <= pbrle_pkg::PH_RUN;
            kind_reg  <= pbrle_pkg::K_NEW;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            pbrle_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = pbrle_pkg::ST_DECIDE;
                end
            end
            pbrle_pkg::ST_DECIDE: begin
                if (!status.op_end && status.match) begin
                    if (status.len_next_max) begin
                        kind_next  = pbrle_pkg::K_MAX;
                        phase_next = pbrle_pkg::PH_RUN;
                        state_next = status.lit_zero ? pbrle_pkg::ST_RUN_HDR
                                                     : pbrle_pkg::ST_LF_HDR;
                    end else begin
                        state_next = pbrle_pkg::ST_IDLE;
                    end
                end else begin
                    kind_next = status.op_end ? pbrle_pkg::K_END : pbrle_pkg::K_NEW;
                    if (status.len_ge_min) begin
                        phase_next = pbrle_pkg::PH_RUN;
                        state_next = status.lit_zero ? pbrle_pkg::ST_RUN_HDR
                                                     : pbrle_pkg::ST_LF_HDR;
                    end else begin
                        phase_next = pbrle_pkg::PH_MOVE;
                        state_next = pbrle_pkg::ST_MOVE;
                    end
                end
            end
            pbrle_pkg::ST_MOVE: begin
                if (!status.len_zero) begin
                    if (status.lit_fill_next) begin
                        state_next = pbrle_pkg::ST_LF_HDR;
                    end
                end else if (kind_reg == pbrle_pkg::K_END && !status.lit_zero) begin
                    phase_next = pbrle_pkg::PH_FINAL;
                    state_next = pbrle_pkg::ST_LF_HDR;
                end else begin
                    state_next = pbrle_pkg::ST_FINISH;
                end
            end
            pbrle_pkg::ST_LF_HDR: begin
                if (status.emit_ready) begin
                    state_next = pbrle_pkg::ST_LF_DATA;
                end
            end
            pbrle_pkg::ST_LF_DATA: begin
                if (status.emit_ready && status.flush_last) begin
                    unique case (phase_reg)
                        pbrle_pkg::PH_RUN:   state_next = pbrle_pkg::ST_RUN_HDR;
                        pbrle_pkg::PH_MOVE:  state_next = pbrle_pkg::ST_MOVE;
                        pbrle_pkg::PH_FINAL: state_next = pbrle_pkg::ST_FINISH;
                        default:             state_next = pbrle_pkg::ST_FINISH;
                    endcase
                end
            end
            pbrle_pkg::ST_RUN_HDR: begin
                if (status.emit_ready) begin
                    state_next = pbrle_pkg::ST_RUN_VAL;
                end
            end
            pbrle_pkg::ST_RUN_VAL: begin
                if (status.emit_ready) begin
                    if (kind_reg == pbrle_pkg::K_END && !status.lit_zero) begin
                        phase_next = pbrle_pkg::PH_FINAL;
                        state_next = pbrle_pkg::ST_LF_HDR;
                    end else begin
                        state_next = pbrle_pkg::ST_FINISH;
                    end
                end
            end
            pbrle_pkg::ST_FINISH: begin
                if (!(status.stage_valid || status.op_end) || status.out_free) begin
                    state_next = pbrle_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // command outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            pbrle_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            pbrle_pkg::ST_DECIDE: begin
                cmd.inc_len = !status.op_end && status.match;
            end
            pbrle_pkg::ST_MOVE: begin
                if (!status.len_zero) begin
                    cmd.add_lit = 1'b1;
                end else begin
                    cmd.clear_run = (kind_reg == pbrle_pkg::K_MAX);
                    cmd.load_run  = (kind_reg == pbrle_pkg::K_NEW);
                end
            end
            pbrle_pkg::ST_LF_HDR: begin
                cmd.emit = status.emit_ready;
                cmd.src  = pbrle_pkg::SRC_LIT_HDR;
            end
            pbrle_pkg::ST_LF_DATA: begin
                cmd.emit        = status.emit_ready;
                cmd.lit_advance = status.emit_ready;
                cmd.src         = pbrle_pkg::SRC_LIT_DATA;
            end
            pbrle_pkg::ST_RUN_HDR: begin
                cmd.emit = status.emit_ready;
                cmd.src  = pbrle_pkg::SRC_RUN_HDR;
            end
            pbrle_pkg::ST_RUN_VAL: begin
                cmd.emit = status.emit_ready;
                cmd.src  = pbrle_pkg::SRC_RUN_VAL;
                if (status.emit_ready) begin
                    cmd.clear_run = (kind_reg == pbrle_pkg::K_MAX);
                    cmd.load_run  = (kind_reg == pbrle_pkg::K_NEW);
                end
            end
            pbrle_pkg::ST_FINISH: begin
                if ((status.stage_valid || status.op_end) && status.out_free) begin
                    cmd.push_final = 1'b1;
                    cmd.reset_all  = status.op_end;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

[hdl/pbrle_dp.sv]
// datapath: run and literal state, literal memory, staging and output registers
`default_nettype none

module pbrle_dp #(
    parameter int MIN_RUN = pbrle_pkg::MIN_RUN_DEF,
    parameter int MAX_RUN = pbrle_pkg::MAX_RUN_DEF,
    parameter int MIN_LIT = pbrle_pkg::MIN_LIT_DEF,
    parameter int MAX_LIT = pbrle_pkg::MAX_LIT_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_op,
    input  wire logic [pbrle_pkg::BYTE_W-1:0]      s_data_byte,
    input  wire pbrle_pkg::dp_cmd_t                cmd,
    output pbrle_pkg::dp_status_t                  status,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [pbrle_pkg::BYTE_W-1:0]      m_out_byte,
    output logic                                   m_has_byte,
    output logic                                   m_last,
    output logic                                   m_end_of_stream,
    output logic      [pbrle_pkg::TOTAL_W-1:0]     m_total_bytes
);

    localparam int AW = $clog2(MAX_LIT);
    localparam int CW = $clog2(MAX_LIT + 1);

    // transaction registers
    logic                            item_op_reg;
    logic [pbrle_pkg::BYTE_W-1:0]    item_byte_reg;

    // encoder state
    logic [pbrle_pkg::BYTE_W-1:0]    run_value_reg, run_value_next;
    logic                            run_valid_reg, run_valid_next;
    logic [pbrle_pkg::LEN_W-1:0]     run_len_reg, run_len_next;
    logic [CW-1:0]                   lit_count_reg, lit_count_next;
    logic [AW-1:0]                   idx_reg, idx_next;
    logic [pbrle_pkg::TOTAL_W-1:0]   byte_total_reg, byte_total_next;

    // staging and output registers
    logic                            stage_valid_reg, stage_valid_next;
    logic [pbrle_pkg::BYTE_W-1:0]    stage_byte_reg, stage_byte_next;
    logic                            m_valid_reg, m_valid_next;
    logic [pbrle_pkg::BYTE_W-1:0]    out_byte_reg, out_byte_next;
    logic                            has_byte_reg, has_byte_next;
    logic                            last_reg, last_next;
    logic                            eos_reg, eos_next;
    logic [pbrle_pkg::TOTAL_W-1:0]   total_reg, total_next;

    logic [pbrle_pkg::BYTE_W-1:0]    lit_data;
    logic [pbrle_pkg::BYTE_W-1:0]    emit_byte;
    logic [CW-1:0]                   idx_inc;
    logic [pbrle_pkg::LEN_W:0]       len_inc;
    logic                            out_free;
    logic                            emit_ready;
    logic                            flush_last;

    // literal buffer
    pbrle_ram #(
        .WIDTH (pbrle_pkg::BYTE_W),
        .DEPTH (MAX_LIT)
    ) u_lit_ram (
        .aclk    (aclk),
        .wr_en   (cmd.add_lit),
        .wr_addr (lit_count_reg[AW-1:0]),
        .wr_data (run_value_reg),
        .rd_addr (idx_next),
        .rd_data (lit_data)
    );

    // status toward the controller
    assign idx_inc    = CW'(idx_reg) + CW'(1);
    assign len_inc    = {1'b0, run_len_reg} + (pbrle_pkg::LEN_W + 1)'(1);
    assign flush_last = (idx_inc == lit_count_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign emit_ready = !stage_valid_reg || out_free;

    always_comb begin
        status               = '0;
        status.op_end        = item_op_reg;
        status.match         = run_valid_reg && (item_byte_reg == run_value_reg);
        status.len_next_max  = (len_inc >= (pbrle_pkg::LEN_W + 1)'(MAX_RUN));
        status.len_ge_min    = (run_len_reg >= pbrle_pkg::LEN_W'(MIN_RUN));
        status.len_zero      = (run_len_reg == '0);
        status.lit_zero      = (lit_count_reg == '0);
        status.lit_fill_next = (lit_count_reg == CW'(MAX_LIT - 1));
        status.flush_last    = flush_last;
        status.emit_ready    = emit_ready;
        status.out_free      = out_free;
        status.stage_valid   = stage_valid_reg;
    end

    // emitted byte select
    always_comb begin
        unique case (cmd.src)
            pbrle_pkg::SRC_LIT_HDR:  emit_byte = pbrle_pkg::BYTE_W'(lit_count_reg)
                                                 - pbrle_pkg::BYTE_W'(MIN_LIT)
                                                 - pbrle_pkg::LIT_BIAS;
            pbrle_pkg::SRC_LIT_DATA: emit_byte = lit_data;
            pbrle_pkg::SRC_RUN_HDR:  emit_byte = run_len_reg - pbrle_pkg::LEN_W'(MIN_RUN);
            pbrle_pkg::SRC_RUN_VAL:  emit_byte = run_value_reg;
        endcase
    end

    // run and literal bookkeeping
    always_comb begin
        run_value_next  = run_value_reg;
        run_valid_next  = run_valid_reg;
        run_len_next    = run_len_reg;
        lit_count_next  = lit_count_reg;
        idx_next        = idx_reg;
        byte_total_next = byte_total_reg;

        if (cmd.inc_len) begin
            run_len_next = len_inc[pbrle_pkg::LEN_W-1:0];
        end else if (cmd.add_lit) begin
            run_len_next   = run_len_reg - pbrle_pkg::LEN_W'(1);
            lit_count_next = lit_count_reg + CW'(1);
        end else if (cmd.clear_run) begin
            run_value_next = '0;
            run_valid_next = 1'b0;
            run_len_next   = '0;
        end else if (cmd.load_run) begin
            run_value_next = item_byte_reg;
            run_valid_next = 1'b1;
            run_len_next   = pbrle_pkg::LEN_W'(1);
        end

        // walk through the literal buffer during a flush
        if (cmd.lit_advance) begin
            if (flush_last) begin
                idx_next       = '0;
                lit_count_next = '0;
            end else begin
                idx_next = idx_reg + AW'(1);
            end
        end

        // saturating count of emitted bytes
        if (cmd.emit && byte_total_reg != '1) begin
            byte_total_next = byte_total_reg + pbrle_pkg::TOTAL_W'(1);
        end

        // end of stream returns to the reset state
        if (cmd.reset_all) begin
            run_value_next  = '0;
            run_valid_next  = 1'b0;
            run_len_next    = '0;
            lit_count_next  = '0;
            idx_next        = '0;
            byte_total_next = '0;
        end
    end

    // staging byte and output register
    always_comb begin
        stage_valid_next = stage_valid_reg;
        stage_byte_next  = stage_byte_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        out_byte_next    = out_byte_reg;
        has_byte_next    = has_byte_reg;
        last_next        = last_reg;
        eos_next         = eos_reg;
        total_next       = total_reg;

        if (cmd.emit) begin
            // a newer byte exists, so the staged one is not the last
            if (stage_valid_reg) begin
                m_valid_next  = 1'b1;
                out_byte_next = stage_byte_reg;
                has_byte_next = 1'b1;
                last_next     = 1'b0;
                eos_next      = 1'b0;
                total_next    = '0;
            end
            stage_valid_next = 1'b1;
            stage_byte_next  = emit_byte;
        end else if (cmd.push_final) begin
            m_valid_next     = 1'b1;
            out_byte_next    = stage_valid_reg ? stage_byte_reg : '0;
            has_byte_next    = stage_valid_reg;
            last_next        = 1'b1;
            eos_next         = item_op_reg;
            total_next       = item_op_reg ? byte_total_reg : '0;
            stage_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_value_reg   <= '0;
            run_valid_reg   <= 1'b0;
            run_len_reg     <= '0;
            lit_count_reg   <= '0;
            idx_reg         <= '0;
            byte_total_reg  <= '0;
            stage_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            run_value_reg   <= run_value_next;
            run_valid_reg   <= run_valid_next;
            run_len_reg     <= run_len_next;
            lit_count_reg   <= lit_count_next;
            idx_reg         <= idx_next;
            byte_total_reg  <= byte_total_next;
            stage_valid_reg <= stage_valid_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_op_reg   <= s_op;
            item_byte_reg <= s_data_byte;
        end
        stage_byte_reg <= stage_byte_next;
        out_byte_reg   <= out_byte_next;
        has_byte_reg   <= has_byte_next;
        last_reg       <= last_next;
        eos_reg        <= eos_next;
        total_reg      <= total_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = out_byte_reg;
    assign m_has_byte      = has_byte_reg;
    assign m_last          = last_reg;
    assign m_end_of_stream = eos_reg;
    assign m_total_bytes   = total_reg;

endmodule

`default_nettype wire

[hdl/packbits_style_rle_encoder.sv]
// PackBits-style run-length encoder: controller, datapath and literal memory
//
// Input channel (s_valid/s_ready): one byte per transaction with s_op = 0, or an
// end-of-stream transaction with s_op = 1 that flushes all pending output,
// reports the encoded length and returns the encoder to its reset state.
// Output channel (m_valid/m_ready): one encoded byte per transaction; m_last marks
// the final byte caused by an input, and an end transaction finishes with
// m_end_of_stream and m_total_bytes (an empty result with m_has_byte = 0 if it
// produced no bytes). A data byte that only extends a run produces nothing.
// Sequencing: the sequencer takes one input at a time and returns to idle before it
// accepts the next. An input that closes a run of MIN_RUN or more, or brings one to
// MAX_RUN, emits the run; any other input first moves bytes into the literal buffer
// and emits any bytes that this causes. The rate is set by the single-step sequencer
// and the one-byte output path. Each emitted byte is held in the staging register
// until the next byte or the final push, so the last one can be flagged.
// Reset (aresetn low, synchronous) clears all run, literal and count state.
// A stalled receiver holds the output register and then the staging byte;
// the sequencer waits and s_ready stays low until the transaction completes.
`default_nettype none

module packbits_style_rle_encoder #(
    parameter int MIN_RUN = pbrle_pkg::MIN_RUN_DEF,
    parameter int MAX_RUN = pbrle_pkg::MAX_RUN_DEF,
    parameter int MIN_LIT = pbrle_pkg::MIN_LIT_DEF,
    parameter int MAX_LIT = pbrle_pkg::MAX_LIT_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_op,
    input  wire logic [pbrle_pkg::BYTE_W-1:0]      s_data_byte,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic      [pbrle_pkg::BYTE_W-1:0]      m_out_byte,
    output logic                                   m_has_byte,
    output logic                                   m_last,
    output logic                                   m_end_of_stream,
    output logic      [pbrle_pkg::TOTAL_W-1:0]     m_total_bytes
);

    pbrle_pkg::dp_cmd_t    cmd;
    pbrle_pkg::dp_status_t status;

    // sequencer
    pbrle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // state, literal buffer and output registers
    pbrle_dp #(
        .MIN_RUN (MIN_RUN),
        .MAX_RUN (MAX_RUN),
        .MIN_LIT (MIN_LIT),
        .MAX_LIT (MAX_LIT)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_op            (s_op),
        .s_data_byte     (s_data_byte),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_has_byte      (m_has_byte),
        .m_last          (m_last),
        .m_end_of_stream (m_end_of_stream),
        .m_total_bytes   (m_total_bytes)
    );

endmodule

`default_nettype wire

[hdl/pbrle_checker.sv]
// port-level checks of the encoder output stream, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module pbrle_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [pbrle_pkg::BYTE_W-1:0]  m_out_byte,
    input wire logic                          m_has_byte,
    input wire logic                          m_last,
    input wire logic                          m_end_of_stream,
    input wire logic [pbrle_pkg::TOTAL_W-1:0] m_total_bytes
);

    // end of stream always closes the input's result group
    `ASSERT_IMPLIES(a_eos_is_last, aclk, aresetn, m_valid && m_end_of_stream, m_last, "end of stream without last")

    // only the closing result of an end transaction may be empty
    `ASSERT_IMPLIES(a_empty_is_eos, aclk, aresetn, m_valid && !m_has_byte, m_end_of_stream && m_last, "empty result outside end of stream")

    // the length report appears only with end of stream
    `ASSERT_IMPLIES(a_total_only_eos, aclk, aresetn, m_valid && !m_end_of_stream, m_total_bytes == '0, "length reported outside end of stream")

    // a stalled result holds its byte
    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_byte), "stalled result changed")

endmodule

bind packbits_style_rle_encoder pbrle_checker u_pbrle_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_out_byte      (m_out_byte),
    .m_has_byte      (m_has_byte),
    .m_last          (m_last),
    .m_end_of_stream (m_end_of_stream),
    .m_total_bytes   (m_total_bytes)
);

`default_nettype wire
